// ===== sv/rcan_pkg.sv =====
// ----------------------------------------------------------------------------
// rcan_pkg: shared types and constants
// Channel widths and the beat layout that moves down the divider row.
// ----------------------------------------------------------------------------
`default_nettype none

package rcan_pkg;

    localparam int CHAN_N = 4;   // red, green, blue, white
    localparam int CHAN_W = 8;
    localparam int SUM_W  = CHAN_W + 1;
    localparam int QUO_W  = CHAN_W;
    // sum * 255 fits in 17 bits (510 * 255 = 130050)
    localparam int REM_W  = SUM_W + CHAN_W;
    // one cell per quotient bit
    localparam int CELL_N = QUO_W;

    localparam logic [CHAN_W-1:0] CHAN_MAX = '1;

    localparam int RED   = 0;
    localparam int GREEN = 1;
    localparam int BLUE  = 2;
    localparam int WHITE = 3;

    typedef logic [CHAN_N-1:0][CHAN_W-1:0] color_t;

    // bypass: result already final in quo, cells leave the beat alone
    typedef struct packed {
        logic                           bypass;
        logic [REM_W-1:0]               dsh;
        logic [CHAN_N-1:0][REM_W-1:0]   rem;
        logic [CHAN_N-1:0][QUO_W-1:0]   quo;
    } div_beat_t;

endpackage

`default_nettype wire

// ===== sv/rcan_front.sv =====
// ----------------------------------------------------------------------------
// rcan_front: channel sums, peak and divider setup
// Forms the four sums, finds the peak, and loads the first beat of the row:
// a finished color for saturating or in-range cases, else sum*255 over peak.
// ----------------------------------------------------------------------------
`default_nettype none

module rcan_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                advance,
    input  wire logic                in_valid,
    input  wire rcan_pkg::color_t    first,
    input  wire rcan_pkg::color_t    second,
    input  wire logic                saturating,
    output logic                     out_valid,
    output rcan_pkg::div_beat_t      out_data
);
    import rcan_pkg::*;

    logic [CHAN_N-1:0][SUM_W-1:0] sum;
    logic [SUM_W-1:0]             max_lo;
    logic [SUM_W-1:0]             max_hi;
    logic [SUM_W-1:0]             peak;
    logic                         valid_reg;
    div_beat_t                    data_reg;
    div_beat_t                    data_next;

    always_comb
    begin
        for (int ch = 0; ch < CHAN_N; ch++)
        begin
            sum[ch] = {1'b0, first[ch]} + {1'b0, second[ch]};
        end
        max_lo = (sum[RED]  > sum[GREEN]) ? sum[RED]  : sum[GREEN];
        max_hi = (sum[BLUE] > sum[WHITE]) ? sum[BLUE] : sum[WHITE];
        peak   = (max_lo > max_hi) ? max_lo : max_hi;
    end

    always_comb
    begin
        // peak below 256 means every sum fits and passes through
        data_next.bypass = saturating | ~peak[SUM_W-1];
        // divisor lined up with the top quotient bit
        data_next.dsh    = {{(REM_W-SUM_W-QUO_W+1){1'b0}}, peak, {(QUO_W-1){1'b0}}};
        for (int ch = 0; ch < CHAN_N; ch++)
        begin
            data_next.rem[ch] = {sum[ch], {CHAN_W{1'b0}}}
                              - {{CHAN_W{1'b0}}, sum[ch]};
            if (saturating && sum[ch][SUM_W-1])
            begin
                data_next.quo[ch] = CHAN_MAX;
            end
            else if (data_next.bypass)
            begin
                data_next.quo[ch] = sum[ch][QUO_W-1:0];
            end
            else
            begin
                data_next.quo[ch] = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

// ===== sv/rcan_cell.sv =====
// ----------------------------------------------------------------------------
// rcan_cell: one restoring-division step
// Settles one quotient bit for all four channels and hands the beat on with
// the divisor shifted down one place.
// ----------------------------------------------------------------------------
`default_nettype none

module rcan_cell (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                advance,
    input  wire logic                in_valid,
    input  wire rcan_pkg::div_beat_t in_data,
    output logic                     out_valid,
    output rcan_pkg::div_beat_t      out_data
);
    import rcan_pkg::*;

    logic      valid_reg;
    div_beat_t data_reg;
    div_beat_t data_next;
    logic      fits;

    always_comb
    begin
        data_next = in_data;
        fits      = 1'b0;
        if (!in_data.bypass)
        begin
            data_next.dsh = in_data.dsh >> 1;
            for (int ch = 0; ch < CHAN_N; ch++)
            begin
                fits = (in_data.rem[ch] >= in_data.dsh);
                if (fits)
                begin
                    data_next.rem[ch] = in_data.rem[ch] - in_data.dsh;
                end
                data_next.quo[ch] = {in_data.quo[ch][QUO_W-2:0], fits};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // remainder stays below the divisor used in this step; the last step
    // shifts out the divisor's low bit, so the bound fills it with a one
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !data_reg.bypass |->
            ({1'b0, data_reg.rem[RED]}   < {data_reg.dsh, 1'b1}) &&
            ({1'b0, data_reg.rem[GREEN]} < {data_reg.dsh, 1'b1}) &&
            ({1'b0, data_reg.rem[BLUE]}  < {data_reg.dsh, 1'b1}) &&
            ({1'b0, data_reg.rem[WHITE]} < {data_reg.dsh, 1'b1}))
        else $error("rcan_cell: remainder out of range");

    // finished colors ride through untouched
    a_bypass_hold: assert property (@(posedge clk) disable iff (!rst_n)
        $past(advance) && $past(in_valid) && $past(in_data.bypass) |->
            valid_reg && data_reg.bypass && (data_reg.quo == $past(in_data.quo)))
        else $error("rcan_cell: bypass beat altered");

    // divisor carries the peak, which is at least 256 here
    a_dsh_live: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !data_reg.bypass |-> (data_reg.dsh != '0))
        else $error("rcan_cell: divisor lost");

endmodule

`default_nettype wire

// ===== sv/rgbw_color_add_normalize.sv =====
// ----------------------------------------------------------------------------
// rgbw_color_add_normalize: RGBW color add, saturating or hue-preserving
// Adds two RGBW colors. Saturating mode clamps each channel to 255; otherwise
// an overflowing color is scaled so its brightest channel lands on 255.
//
//   beat     | dir | handshake               | payload
//   ---------+-----+-------------------------+-------------------------------
//   color    | in  | color_valid/color_ready | first_*, second_*, saturating
//   sum      | out | sum_valid/sum_ready     | sum_red/green/blue/white
//
// One beat per cycle while the output is not stalled; the row is a setup
// stage plus one division cell per quotient bit, 8 cells.
// The whole row moves together: it stalls only when the last cell holds a
// beat that sum_ready has not taken, so color_ready is !sum_valid | sum_ready.
// Reset clears the valid bits of every stage; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbw_color_add_normalize (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          color_valid,
    output logic                               color_ready,
    input  wire logic [rcan_pkg::CHAN_W-1:0]   first_red,
    input  wire logic [rcan_pkg::CHAN_W-1:0]   first_green,
    input  wire logic [rcan_pkg::CHAN_W-1:0]   first_blue,
    input  wire logic [rcan_pkg::CHAN_W-1:0]   first_white,
    input  wire logic [rcan_pkg::CHAN_W-1:0]   second_red,
    input  wire logic [rcan_pkg::CHAN_W-1:0]   second_green,
    input  wire logic [rcan_pkg::CHAN_W-1:0]   second_blue,
    input  wire logic [rcan_pkg::CHAN_W-1:0]   second_white,
    input  wire logic                          saturating,
    output logic                               sum_valid,
    input  wire logic                          sum_ready,
    output logic [rcan_pkg::CHAN_W-1:0]        sum_red,
    output logic [rcan_pkg::CHAN_W-1:0]        sum_green,
    output logic [rcan_pkg::CHAN_W-1:0]        sum_blue,
    output logic [rcan_pkg::CHAN_W-1:0]        sum_white
);
    import rcan_pkg::*;

    logic                  advance;
    color_t                first;
    color_t                second;
    logic      [CELL_N:0]  chain_valid;
    div_beat_t [CELL_N:0]  chain_data;

    assign first[RED]    = first_red;
    assign first[GREEN]  = first_green;
    assign first[BLUE]   = first_blue;
    assign first[WHITE]  = first_white;
    assign second[RED]   = second_red;
    assign second[GREEN] = second_green;
    assign second[BLUE]  = second_blue;
    assign second[WHITE] = second_white;

    assign advance     = ~chain_valid[CELL_N] | sum_ready;
    assign color_ready = advance;

    rcan_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .in_valid   (color_valid),
        .first      (first),
        .second     (second),
        .saturating (saturating),
        .out_valid  (chain_valid[0]),
        .out_data   (chain_data[0])
    );

    for (genvar c = 0; c < CELL_N; c++)
    begin : g_cell
        rcan_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .in_valid  (chain_valid[c]),
            .in_data   (chain_data[c]),
            .out_valid (chain_valid[c+1]),
            .out_data  (chain_data[c+1])
        );
    end

    assign sum_valid = chain_valid[CELL_N];
    assign sum_red   = chain_data[CELL_N].quo[RED];
    assign sum_green = chain_data[CELL_N].quo[GREEN];
    assign sum_blue  = chain_data[CELL_N].quo[BLUE];
    assign sum_white = chain_data[CELL_N].quo[WHITE];

    // a normalized color always has one channel at full scale
    a_full_scale: assert property (@(posedge clk) disable iff (!rst_n)
        sum_valid && !chain_data[CELL_N].bypass |->
            (sum_red == CHAN_MAX) || (sum_green == CHAN_MAX) ||
            (sum_blue == CHAN_MAX) || (sum_white == CHAN_MAX))
        else $error("rgbw_color_add_normalize: peak channel not full scale");

    // a stalled output freezes the whole row
    a_row_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        sum_valid && !sum_ready |=> $stable(chain_valid) && $stable(chain_data))
        else $error("rgbw_color_add_normalize: row moved during stall");

    // an accepted beat shows up at the first stage
    a_front_load: assert property (@(posedge clk) disable iff (!rst_n)
        color_valid && color_ready |=> chain_valid[0])
        else $error("rgbw_color_add_normalize: accepted beat dropped");

endmodule

`default_nettype wire

// ===== test/rgbw_color_add_normalize_test.sv =====
// ----------------------------------------------------------------------------
// rgbw_color_add_normalize_test: self-checking bench for the RGBW color adder
// Drives color pairs in both saturating and normalizing modes, predicts each
// sum, and compares every output beat channel by channel under random
// backpressure on both sides, including one long output stall.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbw_color_add_normalize_test;

    import rcan_pkg::*;

    localparam int HOLD_CYCLES   = 64;
    localparam int DRAIN_CYCLES  = 20;
    localparam int RANDOM_COLORS = 1900;

    // Keeps the expected sums in order and checks every output beat.
    class color_scoreboard;
        color_t expected_sums[$];
        int     mismatches;
        int     sums_checked;
        int     saturated_colors;
        int     passed_colors;
        int     scaled_colors;

        function new();
            mismatches       = 0;
            sums_checked     = 0;
            saturated_colors = 0;
            passed_colors    = 0;
            scaled_colors    = 0;
        endfunction

        function color_t add_colors(color_t a, color_t b, bit sat);
            color_t      result;
            int unsigned chan_sum[CHAN_N];
            int unsigned peak;
            peak = 0;
            for (int c = 0; c < CHAN_N; c++)
            begin
                chan_sum[c] = 32'(a[c]) + 32'(b[c]);
                if (chan_sum[c] > peak)
                    peak = chan_sum[c];
            end
            if (sat)
            begin
                saturated_colors++;
                for (int c = 0; c < CHAN_N; c++)
                    result[c] = (chan_sum[c] > CHAN_MAX) ? CHAN_MAX : chan_sum[c][CHAN_W-1:0];
            end
            else if (peak <= CHAN_MAX)
            begin
                passed_colors++;
                for (int c = 0; c < CHAN_N; c++)
                    result[c] = chan_sum[c][CHAN_W-1:0];
            end
            else
            begin
                // keep the hue: brightest channel lands exactly on 255
                scaled_colors++;
                for (int c = 0; c < CHAN_N; c++)
                    result[c] = CHAN_W'((chan_sum[c] * CHAN_MAX) / peak);
            end
            return result;
        endfunction

        function void note_color(color_t a, color_t b, bit sat);
            expected_sums.push_back(add_colors(a, b, sat));
        endfunction

        function void check_sum(color_t got);
            string  field_name[CHAN_N] = '{"sum_red", "sum_green", "sum_blue", "sum_white"};
            color_t want;
            if (expected_sums.size() == 0)
            begin
                $error("sum beat with no color pending: %h", got);
                mismatches++;
                return;
            end
            want = expected_sums.pop_front();
            sums_checked++;
            for (int c = 0; c < CHAN_N; c++)
                if (got[c] !== want[c])
                begin
                    $error("%s: expected %0d, got %0d", field_name[c], want[c], got[c]);
                    mismatches++;
                end
        endfunction

        function int pending();
            return expected_sums.size();
        endfunction
    endclass

    logic   clk          = 1'b0;
    logic   rst_n        = 1'b0;
    logic   color_valid  = 1'b0;
    logic   color_ready;
    color_t first_color  = '0;
    color_t second_color = '0;
    logic   saturating   = 1'b0;
    logic   sum_valid;
    logic   sum_ready    = 1'b0;
    logic [CHAN_W-1:0] sum_red;
    logic [CHAN_W-1:0] sum_green;
    logic [CHAN_W-1:0] sum_blue;
    logic [CHAN_W-1:0] sum_white;

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  hold_request  = 1'b0;
    int  colors_sent   = 0;

    color_scoreboard sb = new();

    rgbw_color_add_normalize i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .color_valid  (color_valid),
        .color_ready  (color_ready),
        .first_red    (first_color[RED]),
        .first_green  (first_color[GREEN]),
        .first_blue   (first_color[BLUE]),
        .first_white  (first_color[WHITE]),
        .second_red   (second_color[RED]),
        .second_green (second_color[GREEN]),
        .second_blue  (second_color[BLUE]),
        .second_white (second_color[WHITE]),
        .saturating   (saturating),
        .sum_valid    (sum_valid),
        .sum_ready    (sum_ready),
        .sum_red      (sum_red),
        .sum_green    (sum_green),
        .sum_blue     (sum_blue),
        .sum_white    (sum_white)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #400000;
        $display("[rgbw_color_add_normalize] ERROR");
        $finish;
    end

    // Output side: random stalls, plus one long hold-off on request.
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                sum_ready <= 1'b0;
                hold_left--;
            end
            else if (hold_request)
            begin
                sum_ready    <= 1'b0;
                hold_left    = HOLD_CYCLES - 1;
                hold_request = 1'b0;
            end
            else
                sum_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && sum_valid && sum_ready)
                sb.check_sum({sum_white, sum_blue, sum_green, sum_red});
        end
    end

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_color(input color_t a, input color_t b, input bit sat);
        if ($urandom_range(99) < send_idle_pct)
        begin
            color_valid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        first_color  <= a;
        second_color <= b;
        saturating   <= sat;
        color_valid  <= 1'b1;
        do
            @(posedge clk);
        while (!color_ready);
        sb.note_color(a, b, sat);
        colors_sent++;
        @(negedge clk);
    endtask

    task automatic send_random_colors(input int count);
        color_t a;
        color_t b;
        int     t;
        int     pk;
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(3))
                0:
                    for (int c = 0; c < CHAN_N; c++)
                    begin
                        a[c] = CHAN_W'($urandom_range(255));
                        b[c] = CHAN_W'($urandom_range(255));
                    end
                1:
                    // dim colors: normalizing passes the sums through
                    for (int c = 0; c < CHAN_N; c++)
                    begin
                        a[c] = CHAN_W'($urandom_range(127));
                        b[c] = CHAN_W'($urandom_range(127));
                    end
                2:
                    for (int c = 0; c < CHAN_N; c++)
                    begin
                        a[c] = CHAN_W'($urandom_range(255, 128));
                        b[c] = CHAN_W'($urandom_range(255, 128));
                    end
                default:
                begin
                    // peak right at the pass/scale boundary
                    t  = $urandom_range(257, 254);
                    pk = $urandom_range(CHAN_N - 1);
                    for (int c = 0; c < CHAN_N; c++)
                    begin
                        a[c] = CHAN_W'($urandom_range(t / 2));
                        b[c] = CHAN_W'($urandom_range(t / 2));
                    end
                    a[pk] = CHAN_W'($urandom_range((t > 255) ? 255 : t,
                                                   (t > 255) ? t - 255 : 0));
                    b[pk] = CHAN_W'(t - int'(a[pk]));
                end
            endcase
            send_color(a, b, 1'($urandom_range(1)));
        end
    endtask

    initial
    begin
        color_t a;
        color_t b;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle_pct = 24;
        recv_idle_pct = 78;

        send_color('0, '0, 1'b0);
        send_color('0, '0, 1'b1);
        send_color('1, '1, 1'b1);
        send_color('1, '1, 1'b0);
        send_color('1, '0, 1'b0);
        // peak of exactly 255: no scaling
        send_color({8'd100, 8'd0, 8'd10, 8'd200}, {8'd0, 8'd5, 8'd20, 8'd55}, 1'b0);
        // peak of exactly 256: smallest scaled case
        send_color({8'd0, 8'd1, 8'd100, 8'd128}, {8'd0, 8'd1, 8'd100, 8'd128}, 1'b0);
        send_color({8'd0, 8'd0, 8'd0, 8'd255}, {8'd0, 8'd0, 8'd0, 8'd255}, 1'b0);
        send_color({8'd0, 8'd0, 8'd0, 8'd255}, {8'd0, 8'd0, 8'd0, 8'd255}, 1'b1);
        send_color({8'd0, 8'd254, 8'd1, 8'd255}, {8'd255, 8'd1, 8'd255, 8'd1}, 1'b1);
        send_color({4{8'hAA}}, {4{8'h55}}, 1'b0);
        send_color({4{8'h55}}, {4{8'hAA}}, 1'b1);
        // each channel as the brightest in turn
        for (int c = 0; c < CHAN_N; c++)
        begin
            for (int k = 0; k < CHAN_N; k++)
            begin
                a[k] = CHAN_W'($urandom_range(60));
                b[k] = CHAN_W'($urandom_range(60));
            end
            a[c] = 8'd255;
            b[c] = 8'd200;
            send_color(a, b, 1'b0);
            send_color(a, b, 1'b1);
        end

        send_random_colors(RANDOM_COLORS / 3);

        send_idle_pct = 78;
        recv_idle_pct = 24;
        send_random_colors(RANDOM_COLORS / 3);

        // full rate both ways; one long output stall lets the pipe back up
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = 1'b1;
        send_random_colors(RANDOM_COLORS - 2 * (RANDOM_COLORS / 3));
        color_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d colors: %0d saturating, %0d normalizing unscaled, %0d scaled.",
                 colors_sent, sb.saturated_colors, sb.passed_colors, sb.scaled_colors);
        $display("Checked %0d sums across three backpressure mixes and a %0d-cycle stall.",
                 sb.sums_checked, HOLD_CYCLES);
        if (sb.mismatches == 0)
            $display("[rgbw_color_add_normalize] OK");
        else
            $display("[rgbw_color_add_normalize] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
